@@ rtl/dual_accumulator_feature_transform_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the feature transform checker
// Shared forms for concurrent checks clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef DUAL_ACCUMULATOR_FEATURE_TRANSFORM_MACROS_SVH
`define DUAL_ACCUMULATOR_FEATURE_TRANSFORM_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DAFX_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dafx assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DAFX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dafx assertion failed");

`endif

@@ rtl/dafx_pkg.sv @@
// ----------------------------------------------------------------------------
// dafx_pkg
// Types, codes and defaults shared by the feature transform modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dafx_pkg;

  localparam int unsigned NUM_FEATURES_DEF = 40960;
  localparam int unsigned HIDDEN_DEF       = 256;
  localparam int unsigned CNT_W            = 9;
  localparam logic [6:0]  CLIP_MAX         = 7'd127;

  typedef enum logic [2:0] {
    FUNC_RESET     = 3'd0,
    FUNC_ADD       = 3'd1,
    FUNC_SUB       = 3'd2,
    FUNC_EMIT      = 3'd3,
    FUNC_WR_WEIGHT = 3'd4,
    FUNC_WR_BIAS   = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RST,
    ST_FEAT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]         func;
    logic               side;
    logic [15:0]        feature;
    logic [7:0]         neuron;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [5:0] group;
    logic [6:0] out0;
    logic [6:0] out1;
    logic [6:0] out2;
    logic [6:0] out3;
    logic [6:0] out4;
    logic [6:0] out5;
    logic [6:0] out6;
    logic [6:0] out7;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic             accept;
    logic             issue;
    state_e           op;
    logic [CNT_W-1:0] cnt;
  } ctl_t;

endpackage

`default_nettype wire

@@ rtl/dafx_ram.sv @@
// ----------------------------------------------------------------------------
// dafx_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dafx_ram
  import dafx_pkg::*;
#(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2 * HIDDEN_DEF,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/dafx_ctrl.sv @@
// ----------------------------------------------------------------------------
// dafx_ctrl
// Sequencer: takes one item at a time and steps the memory sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module dafx_ctrl
  import dafx_pkg::*;
#(
  parameter int unsigned HIDDEN = HIDDEN_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [2:0] func_i,
  input  wire logic       feat_ok_i,
  input  wire logic       pend_i,
  input  wire logic       out_busy_i,
  output logic            in_stall_o,
  output ctl_t            ctl_o
);

  localparam int unsigned NumGroups = (2 * HIDDEN + 7) / 8;
  localparam logic [CNT_W-1:0] RstLast  = CNT_W'(2 * HIDDEN - 1);
  localparam logic [CNT_W-1:0] FeatLast = CNT_W'(HIDDEN - 1);
  localparam logic [CNT_W-1:0] EmitLast = CNT_W'(8 * NumGroups - 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             accept;
  logic             issue;
  logic             at_end;

  assign accept = in_valid_i && !in_stall_o;

  // outputs
  always_comb begin
    in_stall_o = 1'b1;
    issue      = 1'b0;
    at_end     = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = pend_i;
      ST_RST: begin
        issue  = 1'b1;
        at_end = (cnt_q == RstLast);
      end
      ST_FEAT: begin
        issue  = 1'b1;
        at_end = (cnt_q == FeatLast);
      end
      ST_EMIT: begin
        // open a group only when the output register and read stage are clear
        issue  = !((cnt_q[2:0] == 3'd0) && (out_busy_i || pend_i));
        at_end = (cnt_q == EmitLast);
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          case (func_i)
            FUNC_RESET: state_d = ST_RST;
            FUNC_ADD,
            FUNC_SUB:   state_d = feat_ok_i ? ST_FEAT : ST_IDLE;
            FUNC_EMIT:  state_d = ST_EMIT;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_RST, ST_FEAT, ST_EMIT: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
          if (at_end) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign ctl_o = '{accept: accept, issue: issue, op: state_q, cnt: cnt_q};

endmodule

`default_nettype wire

@@ rtl/dual_accumulator_feature_transform.sv @@
// ----------------------------------------------------------------------------
// dual_accumulator_feature_transform
// Sparse-input dense layer with two perspective accumulators in RAM.
// ----------------------------------------------------------------------------
// Input channel in_*: one item per handshake (valid high, stall low). Items:
// write weight, write bias, reset both accumulators to the bias, add or
// remove one feature's weight row in one perspective, and emit.
// Output channel out_*: one item per group of eight clipped outputs
// (0..127), perspective 0 first, last set on the final group.
// Steps per item, all through the single read port of the accumulator RAM
// (one entry at a time: read, modify, write back in the next cycle):
//   weight or bias write: lands on acceptance; ignored codes: no sweep
//   add or remove: a sweep over the HIDDEN entries of one perspective
//   reset to bias: a sweep over all 2*HIDDEN entries of both perspectives
//   emit: per group, 8 reads, then the output register is loaded and
//   handed over, for ceil(2*HIDDEN/8) groups, plus any time the
//   receiver holds stall (a group waits in the output register).
// The next item is taken once the last write-back of the previous is done.
// Reset clears only the control state; the weight, bias and accumulator
// RAMs hold no defined value until written.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_accumulator_feature_transform
  import dafx_pkg::*;
#(
  parameter int unsigned NUM_FEATURES = NUM_FEATURES_DEF,
  parameter int unsigned HIDDEN       = HIDDEN_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int unsigned AccW      = $clog2(2 * HIDDEN);
  localparam int unsigned BiasW     = $clog2(HIDDEN);
  localparam int unsigned WgtW      = $clog2(NUM_FEATURES * HIDDEN);
  localparam int unsigned NumGroups = (2 * HIDDEN + 7) / 8;

  ctl_t ctl;
  logic feat_ok, neu_ok;

  // hold the item's operands for the length of its sweep
  logic            side_q, sub_q;
  logic [WgtW-1:0] base_q;

  // read stage
  logic             p_v_q;
  state_e           p_op_q;
  logic [CNT_W-1:0] p_cnt_q;
  logic [AccW-1:0]  p_addr_q;

  // memory ports
  logic              w_we, b_we, acc_we;
  logic [WgtW-1:0]   w_wa, w_ra;
  logic [BiasW-1:0]  b_wa, b_ra;
  logic [AccW-1:0]   acc_ra;
  logic [7:0]        w_rd;
  logic [15:0]       b_rd;
  logic [31:0]       acc_rd, acc_wd, w_ext;

  logic [6:0]  lane_q [7];
  logic [6:0]  lane_val;
  logic        out_load;
  out_item_t   out_q, out_d;
  logic        out_valid_q;

  assign feat_ok = {1'b0, in_item_i.feature} < 17'(NUM_FEATURES);
  assign neu_ok  = {1'b0, in_item_i.neuron} < 9'(HIDDEN);

  dafx_ctrl #(.HIDDEN(HIDDEN)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (in_item_i.func),
    .feat_ok_i  (feat_ok),
    .pend_i     (p_v_q),
    .out_busy_i (out_valid_q),
    .in_stall_o (in_stall_o),
    .ctl_o      (ctl)
  );

  always_ff @(posedge clk_i) begin
    if (ctl.accept) begin
      side_q <= in_item_i.side;
      sub_q  <= (in_item_i.func == FUNC_SUB);
      base_q <= WgtW'(32'(in_item_i.feature) * HIDDEN);
    end
  end

  // weight and bias writes land straight from the accepted item
  assign w_we = ctl.accept && (in_item_i.func == FUNC_WR_WEIGHT) && feat_ok && neu_ok;
  assign w_wa = WgtW'(32'(in_item_i.feature) * HIDDEN + 32'(in_item_i.neuron));
  assign b_we = ctl.accept && (in_item_i.func == FUNC_WR_BIAS) && neu_ok;
  assign b_wa = BiasW'(in_item_i.neuron);

  // read addresses for the current sweep step
  always_comb begin
    w_ra   = '0;
    b_ra   = '0;
    acc_ra = '0;
    case (ctl.op)
      ST_RST: begin
        b_ra   = (ctl.cnt < CNT_W'(HIDDEN)) ? BiasW'(ctl.cnt) : BiasW'(ctl.cnt - CNT_W'(HIDDEN));
        acc_ra = AccW'(ctl.cnt);
      end
      ST_FEAT: begin
        w_ra   = base_q + WgtW'(ctl.cnt);
        acc_ra = side_q ? AccW'(ctl.cnt + CNT_W'(HIDDEN)) : AccW'(ctl.cnt);
      end
      ST_EMIT: acc_ra = AccW'(ctl.cnt);
      default: acc_ra = '0;
    endcase
  end

  dafx_ram #(.WIDTH(8), .DEPTH(NUM_FEATURES * HIDDEN)) u_wgt (
    .clk_i (clk_i), .we_i (w_we), .waddr_i (w_wa), .wdata_i (in_item_i.value[7:0]),
    .re_i (ctl.issue), .raddr_i (w_ra), .rdata_o (w_rd)
  );

  dafx_ram #(.WIDTH(16), .DEPTH(HIDDEN)) u_bias (
    .clk_i (clk_i), .we_i (b_we), .waddr_i (b_wa), .wdata_i (in_item_i.value),
    .re_i (ctl.issue), .raddr_i (b_ra), .rdata_o (b_rd)
  );

  dafx_ram #(.WIDTH(32), .DEPTH(2 * HIDDEN)) u_acc (
    .clk_i (clk_i), .we_i (acc_we), .waddr_i (p_addr_q), .wdata_i (acc_wd),
    .re_i (ctl.issue), .raddr_i (acc_ra), .rdata_o (acc_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else begin
      p_v_q <= ctl.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.issue) begin
      p_op_q   <= ctl.op;
      p_cnt_q  <= ctl.cnt;
      p_addr_q <= acc_ra;
    end
  end

  // modify and write back in the cycle after the read; addresses never repeat
  // inside a sweep and the next item waits for the last write
  assign w_ext  = {{24{w_rd[7]}}, w_rd};
  assign acc_we = p_v_q && ((p_op_q == ST_RST) || (p_op_q == ST_FEAT));
  assign acc_wd = (p_op_q == ST_RST) ? {{16{b_rd[15]}}, b_rd}
                : (sub_q ? acc_rd - w_ext : acc_rd + w_ext);

  // clip: negative to zero, saturate at the top; lanes past the end read zero
  always_comb begin
    if (32'(p_cnt_q) >= 32'(2 * HIDDEN) || acc_rd[31]) begin
      lane_val = '0;
    end else if (acc_rd > 32'(CLIP_MAX)) begin
      lane_val = CLIP_MAX;
    end else begin
      lane_val = acc_rd[6:0];
    end
  end

  assign out_load = p_v_q && (p_op_q == ST_EMIT) && (p_cnt_q[2:0] == 3'd7);

  always_ff @(posedge clk_i) begin
    if (p_v_q && (p_op_q == ST_EMIT) && (p_cnt_q[2:0] != 3'd7)) begin
      lane_q[p_cnt_q[2:0]] <= lane_val;
    end
  end

  always_comb begin
    out_d.group = p_cnt_q[8:3];
    out_d.out0  = lane_q[0];
    out_d.out1  = lane_q[1];
    out_d.out2  = lane_q[2];
    out_d.out3  = lane_q[3];
    out_d.out4  = lane_q[4];
    out_d.out5  = lane_q[5];
    out_d.out6  = lane_q[6];
    out_d.out7  = lane_val;
    out_d.last  = (p_cnt_q[8:3] == 6'(NumGroups - 1));
  end

  // the sequencer opens a group only with this register empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/dafx_checker.sv @@
// ----------------------------------------------------------------------------
// dafx_checker
// Port-level checks on the feature transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_accumulator_feature_transform_macros.svh"

module dafx_checker
  import dafx_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  // hold a stalled result item
  `DAFX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  // an emit run in progress keeps the input side closed
  `DAFX_ASSERT(a_emit_busy, clk_i, rst_ni, out_valid_o && !out_item_o.last, in_stall_o)
  // a reset to bias always takes a sweep
  `DAFX_ASSERT_NEXT(a_rst_busy, clk_i, rst_ni, in_valid_i && !in_stall_o && (in_item_i.func == FUNC_RESET), in_stall_o)
  // nothing follows the final group of a run at once
  `DAFX_ASSERT_NEXT(a_last_gap, clk_i, rst_ni, out_valid_o && !out_stall_i && out_item_o.last, !out_valid_o)

endmodule

bind dual_accumulator_feature_transform dafx_checker u_dafx_checker (.*);

`default_nettype wire
